### rtl/rwsc_pkg.sv
// shared types, codes and constants of the reliable window sequence controller
`timescale 1ns / 1ps

package rwsc_pkg;

  // sequence numbering
  localparam int unsigned SEQ_BITS_DEF = 16;
  localparam int unsigned SEQ_MAX_BITS = 32;
  localparam int unsigned SEQ_CMP_W    = SEQ_MAX_BITS + 2;

  // bus widths
  localparam int unsigned TDATA_IN_W  = 88;
  localparam int unsigned TUSER_IN_W  = 3;
  localparam int unsigned TDATA_OUT_W = 40;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MAX = 1'b1;

  // reset values
  localparam logic [15:0] WINDOW_MIN_RST = 16'd64;
  localparam logic [15:0] WINDOW_MAX_RST = 16'd32768;
  localparam logic [15:0] WINDOW_RST     = 16'd1024;

  // timing
  localparam logic [16:0] ACC_MAX       = 17'd131071;
  localparam logic [16:0] MS_PER_ADAPT  = 17'd1000;
  localparam logic [16:0] MS_PER_RATE   = 17'd10000;

  // window steps, signed 18 bit
  localparam logic signed [17:0] STEP_UP_BIG   = 18'sd100;
  localparam logic signed [17:0] STEP_UP_SMALL = 18'sd50;
  localparam logic signed [17:0] STEP_DN_BIG   = -18'sd100;
  localparam logic signed [17:0] STEP_DN_SMALL = -18'sd50;

  // item kinds
  typedef enum logic [2:0] {
    KIND_SEQ_REQ  = 3'd0,
    KIND_PUT_BACK = 3'd1,
    KIND_SENT     = 3'd2,
    KIND_LOSS     = 3'd3,
    KIND_LATE     = 3'd4,
    KIND_TICK     = 3'd5
  } kind_e;

  // one input item
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] seq_in;
    logic        unacked_pending;
    logic [15:0] lowest_unacked;
    logic [15:0] byte_count;
    logic [7:0]  packet_count;
    logic [7:0]  loss_count;
    logic [15:0] elapsed_ms;
  } item_t;

  // saturating 32 bit add
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

### rtl/rwsc_seq_unit.sv
// outgoing sequence number: window check, grant and put-back
`timescale 1ns / 1ps

module rwsc_seq_unit #(
  parameter int unsigned SEQ_BITS = rwsc_pkg::SEQ_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  rwsc_pkg::item_t     item_i,
  input  logic [15:0]         window_i,
  output logic [15:0]         seq_out_o,
  output logic                ok_o
);

  localparam int unsigned CW = rwsc_pkg::SEQ_CMP_W;

  logic [SEQ_BITS-1:0] next_q, next_d;
  logic [rwsc_pkg::SEQ_MAX_BITS-1:0] seq_ext, low_ext;
  logic [SEQ_BITS-1:0] seq_w, low_w;
  logic [SEQ_BITS-1:0] dist_fwd;
  logic [SEQ_BITS:0]   dist_wrap;
  logic [CW-1:0]       dist_c, win_c;
  logic [rwsc_pkg::SEQ_MAX_BITS:0] next_wide;
  logic                grant;

  // mask incoming numbers to the sequence width
  assign seq_ext = {{(rwsc_pkg::SEQ_MAX_BITS-16){1'b0}}, item_i.seq_in};
  assign low_ext = {{(rwsc_pkg::SEQ_MAX_BITS-16){1'b0}}, item_i.lowest_unacked};
  assign seq_w   = seq_ext[SEQ_BITS-1:0];
  assign low_w   = low_ext[SEQ_BITS-1:0];

  // distance from the lowest unacked number, with and without wrap
  assign dist_fwd  = next_q - low_w;
  assign dist_wrap = {1'b0, next_q} + {1'b0, ~low_w};
  assign dist_c    = (low_w < next_q) ? {{(CW-SEQ_BITS){1'b0}}, dist_fwd}
                                      : {{(CW-SEQ_BITS-1){1'b0}}, dist_wrap};
  assign win_c     = {{(CW-16){1'b0}}, window_i};
  assign grant     = !item_i.unacked_pending || (dist_c <= win_c);
  // number zero-extended to a fixed width, low 16 bits go out
  assign next_wide = {{(rwsc_pkg::SEQ_MAX_BITS+1-SEQ_BITS){1'b0}}, next_q};

  // per-kind result and next number
  always_comb begin
    next_d    = next_q;
    seq_out_o = '0;
    ok_o      = 1'b0;
    case (item_i.kind)
      rwsc_pkg::KIND_SEQ_REQ: begin
        if (grant) begin
          seq_out_o = next_wide[15:0];
          ok_o      = 1'b1;
          next_d    = next_q + 1'b1;
        end
      end
      rwsc_pkg::KIND_PUT_BACK: begin
        if (seq_w + 1'b1 == next_q) begin
          next_d = seq_w;
          ok_o   = 1'b1;
        end
      end
      default: begin
        next_d = next_q;
      end
    endcase
  end

  // sequence register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q <= '0;
    end else if (fire_i) begin
      next_q <= next_d;
    end
  end

  // refused request keeps the number
  a_refused_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.kind == rwsc_pkg::KIND_SEQ_REQ && !ok_o) |=> $stable(next_q))
    else $error("refused request moved the sequence number");

  // only requests and put-backs touch the number
  a_other_kinds_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.kind != rwsc_pkg::KIND_SEQ_REQ
            && item_i.kind != rwsc_pkg::KIND_PUT_BACK) |=> $stable(next_q))
    else $error("sequence number changed by a non-sequence item");

endmodule

### rtl/rwsc_win_unit.sv
// packet counters, millisecond accumulators and window adaptation
`timescale 1ns / 1ps

module rwsc_win_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  rwsc_pkg::item_t item_i,
  input  logic [15:0]     window_min_i,
  input  logic [15:0]     window_max_i,
  output logic [15:0]     window_cur_o,
  output logic [15:0]     window_nxt_o
);

  logic [15:0] window_q, window_d;
  logic [31:0] bytes_q, bytes_d;
  logic [31:0] pkt_ok_q, pkt_ok_d;
  logic [31:0] pkt_lost_q, pkt_lost_d;
  logic [31:0] pkt_late_q, pkt_late_d;
  logic [16:0] second_q, second_d;
  logic [16:0] rate_q, rate_d;

  logic [17:0] second_sum;
  logic [16:0] second_sat;
  logic [16:0] rate_sum;
  logic        adapt;
  logic [31:0] loss_sum, loss_c;
  logic [39:0] loss_w, ok_w, loss_x100, loss_x20, loss_x10, ok_x3;
  logic        used, up_big, up_small, dn_big, dn_small;
  logic        step_en;
  logic signed [17:0] step, size, lo_s, hi_s;
  logic [15:0] clamped;

  // accumulators
  assign second_sum = {1'b0, second_q} + {2'b0, item_i.elapsed_ms};
  assign second_sat = (second_sum > {1'b0, rwsc_pkg::ACC_MAX}) ? rwsc_pkg::ACC_MAX
                                                               : second_sum[16:0];
  assign rate_sum   = rate_q + {1'b0, item_i.elapsed_ms};
  assign adapt      = second_sat > rwsc_pkg::MS_PER_ADAPT;

  // clamped loss and exact ratio comparisons
  assign loss_sum  = rwsc_pkg::sat_add32(pkt_lost_q, pkt_late_q);
  assign loss_c    = (loss_sum > pkt_ok_q) ? pkt_ok_q : loss_sum;
  assign loss_w    = {8'b0, loss_c};
  assign ok_w      = {8'b0, pkt_ok_q};
  assign loss_x100 = (loss_w << 6) + (loss_w << 5) + (loss_w << 2);
  assign loss_x20  = (loss_w << 4) + (loss_w << 2);
  assign loss_x10  = (loss_w << 3) + (loss_w << 1);
  assign ok_x3     = (ok_w << 1) + ok_w;
  assign used      = bytes_q > {8'b0, window_q, 8'b0};
  assign up_big    = (loss_x100 < ok_w) || (pkt_ok_q == '0);
  assign up_small  = loss_x20 < ok_w;
  assign dn_big    = loss_x20 > ok_x3;
  assign dn_small  = loss_x10 > ok_w;

  // step selection
  always_comb begin
    step    = '0;
    step_en = 1'b0;
    if (up_big) begin
      step    = rwsc_pkg::STEP_UP_BIG;
      step_en = used;
    end else if (up_small) begin
      step    = rwsc_pkg::STEP_UP_SMALL;
      step_en = used;
    end else if (dn_big) begin
      step    = rwsc_pkg::STEP_DN_BIG;
      step_en = 1'b1;
    end else if (dn_small) begin
      step    = rwsc_pkg::STEP_DN_SMALL;
      step_en = 1'b1;
    end
  end

  // clamp to the configured bounds, low bound first
  assign size = $signed({2'b0, window_q}) + step;
  assign lo_s = $signed({2'b0, window_min_i});
  assign hi_s = $signed({2'b0, window_max_i});
  always_comb begin
    if (size < lo_s) begin
      clamped = window_min_i;
    end else if (size > hi_s) begin
      clamped = window_max_i;
    end else begin
      clamped = size[15:0];
    end
  end

  // per-kind state update
  always_comb begin
    window_d   = window_q;
    bytes_d    = bytes_q;
    pkt_ok_d   = pkt_ok_q;
    pkt_lost_d = pkt_lost_q;
    pkt_late_d = pkt_late_q;
    second_d   = second_q;
    rate_d     = rate_q;
    case (item_i.kind)
      rwsc_pkg::KIND_SENT: begin
        bytes_d  = rwsc_pkg::sat_add32(bytes_q, {16'b0, item_i.byte_count});
        pkt_ok_d = rwsc_pkg::sat_add32(pkt_ok_q, {24'b0, item_i.packet_count});
      end
      rwsc_pkg::KIND_LOSS: begin
        pkt_lost_d = rwsc_pkg::sat_add32(pkt_lost_q, {24'b0, item_i.loss_count});
      end
      rwsc_pkg::KIND_LATE: begin
        pkt_late_d = rwsc_pkg::sat_add32(pkt_late_q, 32'd1);
      end
      rwsc_pkg::KIND_TICK: begin
        second_d = second_sat;
        if (adapt) begin
          second_d   = second_sat - rwsc_pkg::MS_PER_ADAPT;
          pkt_ok_d   = '0;
          pkt_lost_d = '0;
          pkt_late_d = '0;
          if (step_en) begin
            window_d = clamped;
          end
        end
        if (rate_sum > rwsc_pkg::MS_PER_RATE) begin
          bytes_d = '0;
          rate_d  = '0;
        end else begin
          rate_d = rate_sum;
        end
      end
      default: begin
        window_d = window_q;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= rwsc_pkg::WINDOW_RST;
      bytes_q    <= '0;
      pkt_ok_q   <= '0;
      pkt_lost_q <= '0;
      pkt_late_q <= '0;
      second_q   <= '0;
      rate_q     <= '0;
    end else if (fire_i) begin
      window_q   <= window_d;
      bytes_q    <= bytes_d;
      pkt_ok_q   <= pkt_ok_d;
      pkt_lost_q <= pkt_lost_d;
      pkt_late_q <= pkt_late_d;
      second_q   <= second_d;
      rate_q     <= rate_d;
    end
  end

  assign window_cur_o = window_q;
  assign window_nxt_o = window_d;

  // window moves only on a tick that completes a second
  a_window_only_on_adapt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !(item_i.kind == rwsc_pkg::KIND_TICK && adapt)) |=> $stable(window_q))
    else $error("window changed outside adaptation");

endmodule

### rtl/reliable_window_sequence_controller.sv
// top level: input register, sequence and window units, result register, config
// an accepted item passes the input register, then the result register; one item
//   per cycle sustained while the master side keeps m_axis_tready high
// throughput is set by the combinational update of the sequence and counter
//   state between the two registers
// reset (rst_ni, async, active low) clears the valid flags and unit state, window to 1024,
//   bounds to 64 and 32768; item and result data are not reset; no clearing pass
`timescale 1ns / 1ps

module reliable_window_sequence_controller #(
  parameter int unsigned SEQ_BITS = rwsc_pkg::SEQ_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave side
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // seq_in[15:0], unacked_pending[16], lowest_unacked[32:17], byte_count[48:33],
  // packet_count[56:49], loss_count[64:57], elapsed_ms[80:65], zero pad
  input  logic [rwsc_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
  // kind[2:0]
  input  logic [rwsc_pkg::TUSER_IN_W-1:0]     s_axis_tuser,
  // master side
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // seq_out[15:0], ok[16], window[32:17], zero pad
  output logic [rwsc_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rwsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rwsc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  rwsc_pkg::item_t item_q, item_in;
  logic        in_vld_q;
  logic        out_vld_q;
  logic [15:0] out_seq_q;
  logic        out_ok_q;
  logic [15:0] out_win_q;
  logic        out_free, adv, s_fire;
  logic [15:0] win_min_q, win_max_q;
  logic [15:0] seq_out, window_cur, window_nxt;
  logic        ok;

  // handshake
  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // unpack the incoming item
  assign item_in.kind            = s_axis_tuser[2:0];
  assign item_in.seq_in          = s_axis_tdata[15:0];
  assign item_in.unacked_pending = s_axis_tdata[16];
  assign item_in.lowest_unacked  = s_axis_tdata[32:17];
  assign item_in.byte_count      = s_axis_tdata[48:33];
  assign item_in.packet_count    = s_axis_tdata[56:49];
  assign item_in.loss_count      = s_axis_tdata[64:57];
  assign item_in.elapsed_ms      = s_axis_tdata[80:65];

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_fire) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      item_q <= item_in;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_min_q <= rwsc_pkg::WINDOW_MIN_RST;
      win_max_q <= rwsc_pkg::WINDOW_MAX_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rwsc_pkg::CFG_WINDOW_MIN: win_min_q <= cfg_data_i;
        rwsc_pkg::CFG_WINDOW_MAX: win_max_q <= cfg_data_i;
        default: win_min_q <= win_min_q;
      endcase
    end
  end

  rwsc_seq_unit #(
    .SEQ_BITS (SEQ_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (adv),
    .item_i    (item_q),
    .window_i  (window_cur),
    .seq_out_o (seq_out),
    .ok_o      (ok)
  );

  rwsc_win_unit u_win (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (adv),
    .item_i       (item_q),
    .window_min_i (win_min_q),
    .window_max_i (win_max_q),
    .window_cur_o (window_cur),
    .window_nxt_o (window_nxt)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_seq_q <= seq_out;
      out_ok_q  <= ok;
      out_win_q <= window_nxt;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_win_q, out_ok_q, out_seq_q};

  // a nonzero number is only handed out with ok
  a_seq_implies_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_seq_q != '0) |-> out_ok_q)
    else $error("sequence number reported without grant");

  // slave side stalls only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // a moving item always lands in the result register
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("item lost between input and result register");

endmodule

### bench/window_ctrl_checker.sv
// checker that predicts and compares every result of the window sequence controller
`timescale 1ns / 1ps

module window_ctrl_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // seq_in[15:0], unacked_pending[16], lowest_unacked[32:17], byte_count[48:33],
  // packet_count[56:49], loss_count[64:57], elapsed_ms[80:65], zero pad
  input  logic [rwsc_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
  // kind[2:0]
  input  logic [rwsc_pkg::TUSER_IN_W-1:0]  s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // seq_out[15:0], ok[16], window[32:17], zero pad
  input  logic [rwsc_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [rwsc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rwsc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                               fail_count_o,
  output int                               result_count_o,
  output int                               open_count_o,
  output logic [15:0]                      next_seq_o,
  output logic [15:0]                      window_o
);

  localparam logic [31:0] SEQ_TOP     = 32'h0000_FFFF;
  localparam int          MAX_REPORTS = 40;

  // one expected result, packed as on the master side
  typedef struct packed {
    logic [15:0] window;
    logic        ok;
    logic [15:0] seq_out;
  } answer_t;

  answer_t answer_q[$];
  int      fails;
  int      results;

  // predicted controller state
  logic [15:0] win_min;
  logic [15:0] win_max;
  logic [15:0] next_seq;
  logic [15:0] win;
  logic [31:0] bytes_sent;
  logic [31:0] pkts_ok;
  logic [31:0] pkts_lost;
  logic [31:0] pkts_late;
  logic [16:0] ms_second;
  logic [16:0] ms_rate;

  function automatic logic [31:0] saturating_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] total;
    total = 33'(a) + 33'(b);
    return (total > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  // lower bound wins first, then the upper one, even when they are swapped
  function automatic void clamp_window(input longint size);
    if (size < longint'(win_min)) win = win_min;
    else if (size > longint'(win_max)) win = win_max;
    else win = size[15:0];
  endfunction

  // once per second: step the window by the exact loss to success ratio
  function automatic void adapt_window();
    logic [63:0] good;
    logic [63:0] bad;
    logic        busy_link;
    good      = 64'(pkts_ok);
    bad       = 64'(saturating_sum(pkts_lost, pkts_late));
    busy_link = 64'(bytes_sent) > 64'(win) * 64'd256;
    if (bad > good) bad = good;
    pkts_ok   = '0;
    pkts_lost = '0;
    pkts_late = '0;
    if (bad * 64'd100 < good || good == 64'd0) begin
      if (busy_link) clamp_window(longint'(win) + longint'(rwsc_pkg::STEP_UP_BIG));
    end else if (bad * 64'd20 < good) begin
      if (busy_link) clamp_window(longint'(win) + longint'(rwsc_pkg::STEP_UP_SMALL));
    end else if (bad * 64'd20 > good * 64'd3) begin
      clamp_window(longint'(win) + longint'(rwsc_pkg::STEP_DN_BIG));
    end else if (bad * 64'd10 > good) begin
      clamp_window(longint'(win) + longint'(rwsc_pkg::STEP_DN_SMALL));
    end
  endfunction

  // update the predicted state with one item and return its result
  function automatic answer_t apply_event(input rwsc_pkg::item_t ev);
    answer_t     ans;
    logic [31:0] span;
    logic [17:0] ms_total;
    logic        grant;
    ans = '0;
    case (ev.kind)
      rwsc_pkg::KIND_SEQ_REQ: begin
        grant = 1'b1;
        if (ev.unacked_pending) begin
          if (ev.lowest_unacked < next_seq)
            span = 32'(next_seq) - 32'(ev.lowest_unacked);
          else
            span = 32'(next_seq) + (SEQ_TOP - 32'(ev.lowest_unacked));
          grant = (span <= 32'(win));
        end
        if (grant) begin
          ans.seq_out = next_seq;
          ans.ok      = 1'b1;
          next_seq    = next_seq + 16'd1;
        end
      end
      rwsc_pkg::KIND_PUT_BACK: begin
        if (16'(ev.seq_in + 16'd1) == next_seq) begin
          next_seq = ev.seq_in;
          ans.ok   = 1'b1;
        end
      end
      rwsc_pkg::KIND_SENT: begin
        bytes_sent = saturating_sum(bytes_sent, 32'(ev.byte_count));
        pkts_ok    = saturating_sum(pkts_ok, 32'(ev.packet_count));
      end
      rwsc_pkg::KIND_LOSS: pkts_lost = saturating_sum(pkts_lost, 32'(ev.loss_count));
      rwsc_pkg::KIND_LATE: pkts_late = saturating_sum(pkts_late, 32'd1);
      rwsc_pkg::KIND_TICK: begin
        ms_total  = 18'(ms_second) + 18'(ev.elapsed_ms);
        ms_second = (ms_total > 18'(rwsc_pkg::ACC_MAX)) ? rwsc_pkg::ACC_MAX
                                                         : ms_total[16:0];
        ms_rate   = ms_rate + 17'(ev.elapsed_ms);
        if (ms_second > rwsc_pkg::MS_PER_ADAPT) begin
          ms_second = ms_second - rwsc_pkg::MS_PER_ADAPT;
          adapt_window();
        end
        if (ms_rate > rwsc_pkg::MS_PER_RATE) begin
          bytes_sent = '0;
          ms_rate    = '0;
        end
      end
      default: ;
    endcase
    ans.window = win;
    return ans;
  endfunction

  // watch config writes, accepted items and results at each edge
  always @(posedge clk_i or negedge rst_ni) begin : track
    rwsc_pkg::item_t ev;
    answer_t         got;
    answer_t         want;
    if (!rst_ni) begin
      win_min    = rwsc_pkg::WINDOW_MIN_RST;
      win_max    = rwsc_pkg::WINDOW_MAX_RST;
      next_seq   = '0;
      win        = rwsc_pkg::WINDOW_RST;
      bytes_sent = '0;
      pkts_ok    = '0;
      pkts_lost  = '0;
      pkts_late  = '0;
      ms_second  = '0;
      ms_rate    = '0;
      answer_q.delete();
      fails      = 0;
      results    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          rwsc_pkg::CFG_WINDOW_MIN: win_min = cfg_data_i;
          rwsc_pkg::CFG_WINDOW_MAX: win_max = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        ev.kind            = s_axis_tuser;
        ev.seq_in          = s_axis_tdata[15:0];
        ev.unacked_pending = s_axis_tdata[16];
        ev.lowest_unacked  = s_axis_tdata[32:17];
        ev.byte_count      = s_axis_tdata[48:33];
        ev.packet_count    = s_axis_tdata[56:49];
        ev.loss_count      = s_axis_tdata[64:57];
        ev.elapsed_ms      = s_axis_tdata[80:65];
        answer_q.push_back(apply_event(ev));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[32:0];
        results++;
        if (answer_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: result with none expected, got seq %0d ok %0d window %0d",
                     $time, got.seq_out, got.ok, got.window);
        end else begin
          want = answer_q.pop_front();
          if (got.seq_out !== want.seq_out || got.ok !== want.ok
              || got.window !== want.window) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("%0t: mismatch, expected seq %0d ok %0d window %0d, %s%0d %0d %0d",
                       $time, want.seq_out, want.ok, want.window,
                       "got seq/ok/window ", got.seq_out, got.ok, got.window);
          end
        end
      end
    end
    fail_count_o   <= fails;
    result_count_o <= results;
    open_count_o   <= answer_q.size();
    next_seq_o     <= next_seq;
    window_o       <= win;
  end

endmodule

### bench/reliable_window_sequence_controller_tb.sv
// testbench top: stimulus, handshake pacing and verdict for the window sequence controller
`timescale 1ns / 1ps

module reliable_window_sequence_controller_tb;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 2;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 320;

  // kinds outside the defined set, answered without any state change
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [rwsc_pkg::TDATA_IN_W-1:0]  s_axis_tdata  = '0;
  logic [rwsc_pkg::TUSER_IN_W-1:0]  s_axis_tuser  = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [rwsc_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
  logic                             cfg_valid_i   = 1'b0;
  logic                             cfg_ready_o;
  logic [rwsc_pkg::CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [rwsc_pkg::CFG_DATA_W-1:0]  cfg_data_i    = '0;

  int          fail_count;
  int          result_count;
  int          open_count;
  logic [15:0] next_seq_hint;
  logic [15:0] window_hint;

  int rx_idle_pct = 0;
  int tx_idle_pct = 0;
  int hold_token  = 0;
  int items_sent  = 0;
  int loss_cap    = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  reliable_window_sequence_controller dut (.*);

  window_ctrl_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .result_count_o (result_count),
    .open_count_o   (open_count),
    .next_seq_o     (next_seq_hint),
    .window_o       (window_hint)
  );

  // offer one item after a random gap and wait until it is taken
  task automatic push_item(input rwsc_pkg::item_t ev);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev.kind;
    s_axis_tdata  <= {7'd0, ev.elapsed_ms, ev.loss_count, ev.packet_count, ev.byte_count,
                      ev.lowest_unacked, ev.unacked_pending, ev.seq_in};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic post(input logic [2:0] kind, input logic [15:0] seq, input logic pend,
                      input logic [15:0] low, input logic [15:0] bytes,
                      input logic [7:0] pkts, input logic [7:0] lost,
                      input logic [15:0] ms);
    rwsc_pkg::item_t ev;
    ev.kind            = kind;
    ev.seq_in          = seq;
    ev.unacked_pending = pend;
    ev.lowest_unacked  = low;
    ev.byte_count      = bytes;
    ev.packet_count    = pkts;
    ev.loss_count      = lost;
    ev.elapsed_ms      = ms;
    push_item(ev);
  endtask

  // random item, steered toward the window edge and valid put-backs
  task automatic post_random();
    rwsc_pkg::item_t ev;
    int              pick;
    int              gap;
    ev.seq_in          = 16'($urandom);
    ev.unacked_pending = 1'($urandom);
    ev.lowest_unacked  = 16'($urandom);
    ev.byte_count      = 16'($urandom);
    ev.packet_count    = 8'($urandom);
    ev.loss_count      = 8'($urandom);
    ev.elapsed_ms      = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      ev.kind            = rwsc_pkg::KIND_SEQ_REQ;
      ev.unacked_pending = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 5) gap = $urandom_range(0, int'(window_hint) + 2);
      else if (pick < 8) gap = int'(window_hint) + int'($urandom_range(0, 3)) - 1;
      else gap = $urandom_range(0, 65535);
      ev.lowest_unacked = 16'(int'(next_seq_hint) - gap);
    end else if (pick < 48) begin
      ev.kind = rwsc_pkg::KIND_PUT_BACK;
      pick = $urandom_range(0, 9);
      if (pick < 6) ev.seq_in = next_seq_hint - 16'd1;
      else if (pick < 8) ev.seq_in = next_seq_hint - 16'(1 + $urandom_range(1, 3));
    end else if (pick < 66) begin
      ev.kind = rwsc_pkg::KIND_SENT;
      if ($urandom_range(0, 1) == 1) ev.byte_count = 16'($urandom_range(40000, 65535));
    end else if (pick < 76) begin
      ev.kind       = rwsc_pkg::KIND_LOSS;
      ev.loss_count = 8'($urandom_range(0, loss_cap));
    end else if (pick < 82) begin
      ev.kind = rwsc_pkg::KIND_LATE;
    end else begin
      ev.kind = rwsc_pkg::KIND_TICK;
      pick = $urandom_range(0, 99);
      if (pick < 85) ev.elapsed_ms = 16'($urandom_range(0, 600));
      else if (pick < 95) ev.elapsed_ms = 16'($urandom_range(900, 1100));
      // new loss level for the coming second
      case ($urandom_range(0, 5))
        0: loss_cap = 0;
        1: loss_cap = 4;
        2: loss_cap = 12;
        3: loss_cap = 40;
        4: loss_cap = 120;
        default: loss_cap = 255;
      endcase
    end
    push_item(ev);
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (result_count != items_sent) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // set the window bounds while idle, then run random items
  task automatic run_phase(input logic [15:0] lo, input logic [15:0] hi,
                           input int tx_pct, input int rx_pct, input bit squeeze);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= rwsc_pkg::CFG_WINDOW_MIN;
    cfg_data_i  <= lo;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= rwsc_pkg::CFG_WINDOW_MAX;
    cfg_data_i  <= hi;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    if (squeeze) hold_token <= hold_token + 1;
    repeat (PHASE_ITEMS) post_random();
  endtask

  // receiver: random ready, with one long hold-off on request
  initial begin : rx_side
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: grants, refusals, put-backs, wrap, counters, ticks, spare kinds
    post(rwsc_pkg::KIND_SEQ_REQ,  16'd0,    1'b0, 16'd0,    16'd0,    8'd0,  8'd0,  16'd0);
    post(rwsc_pkg::KIND_SEQ_REQ,  16'd0,    1'b1, 16'd0,    16'd0,    8'd0,  8'd0,  16'd0);
    post(rwsc_pkg::KIND_PUT_BACK, 16'd1,    1'b0, 16'd0,    16'd0,    8'd0,  8'd0,  16'd0);
    post(rwsc_pkg::KIND_PUT_BACK, 16'd7,    1'b0, 16'd0,    16'd0,    8'd0,  8'd0,  16'd0);
    post(rwsc_pkg::KIND_PUT_BACK, 16'd0,    1'b0, 16'd0,    16'd0,    8'd0,  8'd0,  16'd0);
    post(rwsc_pkg::KIND_PUT_BACK, 16'hFFFF, 1'b0, 16'd0,    16'd0,    8'd0,  8'd0,  16'd0);
    post(rwsc_pkg::KIND_SEQ_REQ,  16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
         16'hFFFF);
    post(rwsc_pkg::KIND_SEQ_REQ,  16'd0,    1'b0, 16'd0,    16'd0,    8'd0,  8'd0,  16'd0);
    post(rwsc_pkg::KIND_SEQ_REQ,  16'd0,    1'b1, 16'd0,    16'd0,    8'd0,  8'd0,  16'd0);
    post(rwsc_pkg::KIND_SEQ_REQ,  16'd0,    1'b1, 16'hFFFF, 16'd0,    8'd0,  8'd0,  16'd0);
    post(rwsc_pkg::KIND_SENT,     16'd0,    1'b0, 16'd0,    16'hFFFF, 8'hFF, 8'd0,  16'd0);
    post(rwsc_pkg::KIND_SENT,     16'hFFFF, 1'b1, 16'hFFFF, 16'd0,    8'd0,  8'hFF,
         16'hFFFF);
    post(rwsc_pkg::KIND_LOSS,     16'd0,    1'b0, 16'd0,    16'd0,    8'd0,  8'hFF, 16'd0);
    post(rwsc_pkg::KIND_LOSS,     16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'd0,
         16'hFFFF);
    post(rwsc_pkg::KIND_LATE,     16'd0,    1'b0, 16'd0,    16'd0,    8'd0,  8'd0,  16'd0);
    post(rwsc_pkg::KIND_TICK,     16'd0,    1'b0, 16'd0,    16'd0,    8'd0,  8'd0,  16'd0);
    post(rwsc_pkg::KIND_TICK,     16'd0,    1'b0, 16'd0,    16'd0,    8'd0,  8'd0,  16'd1000);
    post(rwsc_pkg::KIND_TICK,     16'd0,    1'b0, 16'd0,    16'd0,    8'd0,  8'd0,  16'd1);
    // huge ticks drive the second accumulator into saturation
    post(rwsc_pkg::KIND_TICK,     16'd0,    1'b0, 16'd0,    16'd0,    8'd0,  8'd0,  16'hFFFF);
    post(rwsc_pkg::KIND_TICK,     16'd0,    1'b0, 16'd0,    16'd0,    8'd0,  8'd0,  16'hFFFF);
    post(rwsc_pkg::KIND_TICK,     16'd0,    1'b0, 16'd0,    16'd0,    8'd0,  8'd0,  16'hFFFF);
    post(KIND_SPARE_LO,           16'd0,    1'b0, 16'd0,    16'd0,    8'd0,  8'd0,  16'd0);
    post(KIND_SPARE_HI,           16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
         16'hFFFF);

    // random phases over several bound settings and pacing patterns
    run_phase(16'd64,    16'd32768, 27, 70, 1'b0);
    run_phase(16'd1,     16'd65535, 27, 70, 1'b0);
    run_phase(16'd900,   16'd1000,  70, 27, 1'b0);
    run_phase(16'd2000,  16'd500,   70, 27, 1'b0);
    run_phase(16'd65535, 16'd1,     0,  0,  1'b1);
    run_phase(16'd64,    16'd2048,  0,  0,  1'b0);
    wait_drained();

    if (fail_count == 0 && open_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rwsc_pkg.sv
rtl/rwsc_seq_unit.sv
rtl/rwsc_win_unit.sv
rtl/reliable_window_sequence_controller.sv
bench/window_ctrl_checker.sv
bench/reliable_window_sequence_controller_tb.sv
